// ===== sv/cwc_pkg.sv =====
// Package for the congestion window controller.
// Holds widths, reset values, operation and register index codes and the
// state and result structures. It depends on nothing else.
`default_nettype none

package cwc_pkg;

    localparam int SEQ_BITS      = 16;
    localparam int WIN_BITS      = 16;
    localparam int TIME_BITS     = 32;
    localparam int RTT_BITS      = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [SEQ_BITS-1:0]      t_seq;
    typedef logic [WIN_BITS-1:0]      t_win;
    typedef logic [TIME_BITS-1:0]     t_time;
    typedef logic [RTT_BITS-1:0]      t_rtt;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;
    typedef logic [1:0]               t_fill;

    localparam t_win  WIN_MAX            = '1;
    localparam t_win  THRESH_FLOOR       = t_win'(2);
    localparam t_fill FILL_FULL          = t_fill'(3);
    localparam t_fill FILL_DUP_READY     = t_fill'(2);
    localparam t_win  INIT_WINDOW_RESET  = t_win'(1);
    localparam t_win  INIT_THRESH_RESET  = t_win'(64);
    localparam t_rtt  RTT_RESET          = t_rtt'(2);
    localparam t_seq  TOTAL_RESET        = '0;

    typedef enum logic {
        OP_ACK  = 1'b0,
        OP_LOSS = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_INIT_WINDOW = 2'd0,
        CFG_INIT_THRESH = 2'd1,
        CFG_RTT         = 2'd2,
        CFG_TOTAL       = 2'd3
    } t_cfg_idx;

    // Connection state. Only the two newest history entries are kept: the
    // newest of the three compared entries is the incoming ack number.
    typedef struct packed {
        t_win  window;
        t_win  threshold;
        logic  avoid;
        t_seq  acked;
        t_time last_time;
        t_fill fill;
        t_seq  hist_old;
        t_seq  hist_new;
    } t_state;

    typedef struct packed {
        t_win window_size;
        t_win threshold;
        logic avoid_mode;
        logic resend;
        t_seq resend_sequence;
        logic transfer_done;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/cwc_update.sv =====
// Next state and result of the congestion window controller for one request.
// Purely combinational; uses cwc_pkg.
`default_nettype none

module cwc_update (
    input  wire cwc_pkg::t_state  i_state,
    input  wire cwc_pkg::t_op     i_op,
    input  wire cwc_pkg::t_seq    i_ack_number,
    input  wire cwc_pkg::t_time   i_now_seconds,
    input  wire cwc_pkg::t_win    i_init_window,
    input  wire cwc_pkg::t_rtt    i_rtt,
    input  wire cwc_pkg::t_seq    i_total,
    output cwc_pkg::t_state       o_next,
    output cwc_pkg::t_result      o_result
);
    import cwc_pkg::*;

    function automatic t_win sat_inc(t_win w);
        return (w == WIN_MAX) ? w : t_win'(w + t_win'(1));
    endfunction

    function automatic t_win half_floor(t_win w);
        t_win h;
        h = w >> 1;
        return (h < THRESH_FLOOR) ? THRESH_FLOOR : h;
    endfunction

    t_win  eff_init_window;
    t_win  grown;
    t_time elapsed;
    logic  rtt_passed;
    logic  triple_dup;

    // A zero initial window behaves as one.
    assign eff_init_window = (i_init_window == '0) ? INIT_WINDOW_RESET : i_init_window;
    assign grown           = sat_inc(i_state.window);
    assign elapsed         = i_now_seconds - i_state.last_time;
    assign rtt_passed      = (i_now_seconds >= i_state.last_time) &&
                             (elapsed >= t_time'(i_rtt));

    always_comb begin
        o_next     = i_state;
        triple_dup = 1'b0;
        o_result   = '0;

        if (i_op == OP_LOSS) begin
            o_next.threshold = half_floor(i_state.window);
            if (i_state.avoid) begin
                o_next.avoid  = 1'b0;
                o_next.window = eff_init_window;
            end else begin
                o_next.avoid = 1'b1;
            end
        end else begin
            o_next.hist_old = i_state.hist_new;
            o_next.hist_new = i_ack_number;
            if (i_state.fill != FILL_FULL) begin
                o_next.fill = t_fill'(i_state.fill + t_fill'(1));
            end

            if (i_ack_number > i_state.acked) begin
                o_next.acked = i_ack_number;
                if (!i_state.avoid) begin
                    o_next.window = grown;
                    if (grown >= i_state.threshold) begin
                        o_next.avoid     = 1'b1;
                        o_next.last_time = i_now_seconds;
                    end
                end else if (rtt_passed) begin
                    o_next.window    = grown;
                    o_next.last_time = i_now_seconds;
                end
            end

            triple_dup = (o_next.acked != i_total) &&
                         (i_state.fill >= FILL_DUP_READY) &&
                         (i_state.hist_old == i_state.hist_new) &&
                         (i_state.hist_new == i_ack_number);

            if (triple_dup) begin
                o_next.threshold = half_floor(o_next.window);
                if (o_next.avoid) begin
                    o_next.avoid  = 1'b0;
                    o_next.window = eff_init_window;
                end else begin
                    o_next.avoid = 1'b1;
                end
                o_result.resend          = 1'b1;
                o_result.resend_sequence = t_seq'(i_ack_number + t_seq'(1));
            end
        end

        o_result.window_size   = o_next.window;
        o_result.threshold     = o_next.threshold;
        o_result.avoid_mode    = o_next.avoid;
        o_result.transfer_done = (o_next.acked == i_total);
    end

endmodule

`default_nettype wire

// ===== sv/congestion_window_control.sv =====
// Top level of the congestion window controller for one sender connection.
// Uses cwc_pkg and cwc_update.
//
// Usage. Requests enter on the input channel (i_valid / o_ready) and carry an
// operation: an acknowledgement with its cumulative ack number and the time in
// seconds, or a loss event such as a timeout. Every request gives exactly one
// result on the output channel (o_valid / i_ready): the window, the slow start
// threshold, the mode, a retransmit request on a triple duplicate
// acknowledgement, and a flag that the whole transfer has been acknowledged.
// The result is registered: a request that is taken shows its result in the
// cycle after. Throughput is one request per cycle while results are taken;
// the whole update is short combinational logic from the connection state
// registers back into them, so each request sees the state of the one before.
// The result register is reloaded whenever it is empty or its result is taken
// in the same cycle, so a request is taken while a finished result leaves.
// If the receiver stalls with a result held, o_ready drops and the held
// result stays unchanged until it is taken.
// Reset (synchronous, active low) returns the configuration registers to their
// defaults and the connection to slow start with a window of one and a
// threshold of 64. The initial threshold register only matters at reset,
// which restores its default, so writes to it are accepted and dropped.
`default_nettype none

module congestion_window_control (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire cwc_pkg::t_cfg_idx  i_cfg_index,
    input  wire cwc_pkg::t_cfg_data i_cfg_data,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire cwc_pkg::t_op       i_op,
    input  wire cwc_pkg::t_seq      i_ack_number,
    input  wire cwc_pkg::t_time     i_now_seconds,
    output logic                    o_valid,
    input  wire                     i_ready,
    output cwc_pkg::t_win           o_window_size,
    output cwc_pkg::t_win           o_threshold,
    output logic                    o_avoid_mode,
    output logic                    o_resend,
    output cwc_pkg::t_seq           o_resend_sequence,
    output logic                    o_transfer_done
);
    import cwc_pkg::*;

    // Configuration registers.
    t_win    r_init_window;
    t_rtt    r_rtt;
    t_seq    r_total;

    // Connection state and the result register.
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    accept;

    // The result register can take a new result when empty or being drained.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_window <= INIT_WINDOW_RESET;
            r_rtt         <= RTT_RESET;
            r_total       <= TOTAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INIT_WINDOW: r_init_window <= t_win'(i_cfg_data);
                CFG_INIT_THRESH: ;
                CFG_RTT:         r_rtt         <= t_rtt'(i_cfg_data);
                CFG_TOTAL:       r_total       <= t_seq'(i_cfg_data);
                default: ;
            endcase
        end
    end

    cwc_update u_update (
        .i_state       (r_state),
        .i_op          (i_op),
        .i_ack_number  (i_ack_number),
        .i_now_seconds (i_now_seconds),
        .i_init_window (r_init_window),
        .i_rtt         (r_rtt),
        .i_total       (r_total),
        .o_next        (n_state),
        .o_result      (n_result)
    );

    // State update. The ack history is payload and is not cleared; the fill
    // count guarantees that unwritten entries are never compared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.window    <= INIT_WINDOW_RESET;
            r_state.threshold <= INIT_THRESH_RESET;
            r_state.avoid     <= 1'b0;
            r_state.acked     <= '0;
            r_state.last_time <= '0;
            r_state.fill      <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_window_size     = r_result.window_size;
    assign o_threshold       = r_result.threshold;
    assign o_avoid_mode      = r_result.avoid_mode;
    assign o_resend          = r_result.resend;
    assign o_resend_sequence = r_result.resend_sequence;
    assign o_transfer_done   = r_result.transfer_done;

endmodule

`default_nettype wire

// ===== sv/cwc_checker.sv =====
// Port-level checker for the congestion window controller, bound to the top.
// Uses cwc_pkg for the port types.
`default_nettype none

module cwc_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_valid,
    input wire                 i_ready,
    input wire cwc_pkg::t_win  o_window_size,
    input wire cwc_pkg::t_win  o_threshold,
    input wire                 o_resend,
    input wire cwc_pkg::t_seq  o_resend_sequence
);
    import cwc_pkg::*;

    // No result can be pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result holds its window.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_window_size))
        else $error("stalled result changed");

    a_window_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_window_size != '0)
        else $error("window of zero reported");

    a_thresh_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_threshold >= THRESH_FLOOR)
        else $error("threshold below floor");

    a_resend_seq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_resend |-> o_resend_sequence == '0)
        else $error("resend sequence set without resend");

endmodule

bind congestion_window_control cwc_checker u_cwc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_window_size     (o_window_size),
    .o_threshold       (o_threshold),
    .o_resend          (o_resend),
    .o_resend_sequence (o_resend_sequence)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for congestion_window_control.
// Drives acknowledgement and loss requests and checks every result against a
// predictor of the window logic written here. Depends on cwc_pkg and the RTL.
`default_nettype none

module testbench;

    import cwc_pkg::*;

    // A generous bound on the run. The slowest correct run is about 600
    // requests, each paying a sender gap, a receiver stall and the result
    // register of the block, plus the idle waits around the register writes.
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 92;
    localparam int SETTLE_CYCLES = 4;

    // One row of the directed table: either a register write or a request.
    // A request row may carry its expected result typed in; the others take
    // the predictor's answer.
    typedef struct packed {
        logic      is_write;
        t_cfg_idx  idx;
        t_cfg_data data;
        t_op       op;
        t_seq      ack;
        t_time     now;
        logic      typed;
        t_result   want;
    } t_row;

    logic      i_clk         = 1'b0;
    logic      i_rst_n       = 1'b0;
    logic      i_cfg_we      = 1'b0;
    t_cfg_idx  i_cfg_index   = CFG_INIT_WINDOW;
    t_cfg_data i_cfg_data    = '0;
    logic      i_valid       = 1'b0;
    t_op       i_op          = OP_ACK;
    t_seq      i_ack_number  = '0;
    t_time     i_now_seconds = '0;
    logic      i_ready       = 1'b0;

    logic      o_ready;
    logic      o_valid;
    t_win      o_window_size;
    t_win      o_threshold;
    logic      o_avoid_mode;
    logic      o_resend;
    t_seq      o_resend_sequence;
    logic      o_transfer_done;

    // The typed expectation travels with the request, so the scoreboard
    // picks it up at the very edge where the request is accepted.
    logic      drv_typed = 1'b0;
    t_result   drv_want  = '0;

    congestion_window_control dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_op              (i_op),
        .i_ack_number      (i_ack_number),
        .i_now_seconds     (i_now_seconds),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_window_size     (o_window_size),
        .o_threshold       (o_threshold),
        .o_avoid_mode      (o_avoid_mode),
        .o_resend          (o_resend),
        .o_resend_sequence (o_resend_sequence),
        .o_transfer_done   (o_transfer_done)
    );

    always #2 i_clk = ~i_clk;

    // Reset is held at the start and never asserted again.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Predictor: a private copy of the connection state and of the
    // registers that the window logic reads after reset.
    // ------------------------------------------------------------------
    t_win  win      = INIT_WINDOW_RESET;
    t_win  thresh   = INIT_THRESH_RESET;
    logic  avoiding = 1'b0;
    t_seq  acked    = '0;
    t_time last_inc = '0;
    t_seq  dup_hist [3];
    t_fill dup_fill = '0;

    // The initial threshold register is not modeled: its value only
    // matters at reset, and reset happens once before any write.
    t_win  reg_init_window = INIT_WINDOW_RESET;
    t_rtt  reg_rtt         = RTT_RESET;
    t_seq  reg_total       = TOTAL_RESET;

    // Loss reaction: halve the window into the threshold (never below the
    // floor). Slow start moves to avoidance and keeps the window; avoidance
    // falls back to slow start with the initial window, where zero acts as one.
    function automatic void react_to_loss();
        t_win half;
        half   = win >> 1;
        thresh = (half < THRESH_FLOOR) ? THRESH_FLOOR : half;
        if (!avoiding) begin
            avoiding = 1'b1;
        end else begin
            avoiding = 1'b0;
            win      = (reg_init_window == '0) ? t_win'(1) : reg_init_window;
        end
    endfunction

    function automatic t_result window_after(t_op op, t_seq ack, t_time now);
        t_result r;
        r = '0;
        if (op == OP_LOSS) begin
            // A loss event leaves the history and the acked count alone.
            react_to_loss();
        end else begin
            dup_hist[0] = dup_hist[1];
            dup_hist[1] = dup_hist[2];
            dup_hist[2] = ack;
            if (dup_fill != FILL_FULL) begin
                dup_fill = dup_fill + 1'b1;
            end
            if (ack > acked) begin
                acked = ack;
                if (!avoiding) begin
                    if (win != WIN_MAX) begin
                        win = win + 1'b1;
                    end
                    if (win >= thresh) begin
                        avoiding = 1'b1;
                        last_inc = now;
                    end
                end else if (now >= last_inc && now - last_inc >= t_time'(reg_rtt)) begin
                    // Time running backwards never allows an increase.
                    if (win != WIN_MAX) begin
                        win = win + 1'b1;
                    end
                    last_inc = now;
                end
            end
            // Three equal acknowledgements mean a loss, unless the transfer
            // is complete. The history is not cleared, so a fourth equal
            // acknowledgement reacts once more.
            if (acked != reg_total && dup_fill == FILL_FULL &&
                dup_hist[0] == dup_hist[1] && dup_hist[1] == dup_hist[2]) begin
                react_to_loss();
                r.resend          = 1'b1;
                r.resend_sequence = t_seq'(dup_hist[0] + 1'b1);
            end
        end
        r.window_size   = win;
        r.threshold     = thresh;
        r.avoid_mode    = avoiding;
        r.transfer_done = (acked == reg_total);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard. Results leave in request order, so the oldest pending
    // report is the one that the next result must match.
    // ------------------------------------------------------------------
    t_result due_reports [$];
    int      mismatches = 0;
    int      cycles     = 0;

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Both channels are sampled at the rising edge, before any of this
    // edge's nonblocking updates, so the handshake seen here is the one the
    // block saw. A result that leaves at this edge belongs to an earlier
    // request, so it is checked before this edge's request is predicted.
    always @(posedge i_clk) begin : score
        t_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (due_reports.size() == 0) begin
                    $display("%0t: result with no request pending, window %0h",
                             $time, o_window_size);
                    mismatches++;
                end else begin
                    want = due_reports.pop_front();
                    compare_field("window_size", 32'(want.window_size),
                                  32'(o_window_size));
                    compare_field("threshold", 32'(want.threshold), 32'(o_threshold));
                    compare_field("avoid_mode", 32'(want.avoid_mode), 32'(o_avoid_mode));
                    compare_field("resend", 32'(want.resend), 32'(o_resend));
                    compare_field("resend_sequence", 32'(want.resend_sequence),
                                  32'(o_resend_sequence));
                    compare_field("transfer_done", 32'(want.transfer_done),
                                  32'(o_transfer_done));
                end
            end
            if (i_valid && o_ready) begin
                // The predictor runs on every request to keep its state, even
                // where the table supplies the expected result itself.
                want = window_after(i_op, i_ack_number, i_now_seconds);
                due_reports.push_back(drv_typed ? drv_want : want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, due_reports.size());
            $display("[congestion_window_control] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Idle pattern shared by both sides: a random gap before each request,
    // broken now and then by a calm stretch with no gaps at all.
    // ------------------------------------------------------------------
    int send_calm = 0;
    int recv_calm = 0;

    function automatic int idle_cycles(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // Receiver: may stall before each result, then holds ready high until one
    // is taken.
    initial begin : receiver
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = idle_cycles(recv_calm);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    t_seq  sent_top  = '0;   // highest ack number sent, equal to the acked count
    t_seq  sent_last = '0;   // ack number of the latest acknowledgement request

    task automatic send_request(input t_op op, input t_seq ack, input t_time now,
                                input logic typed, input t_result want);
        int gap;
        gap = idle_cycles(send_calm);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_ack_number  <= ack;
        i_now_seconds <= now;
        drv_typed     <= typed;
        drv_want      <= want;
        if (op == OP_ACK) begin
            sent_last = ack;
            if (ack > sent_top) begin
                sent_top = ack;
            end
        end
        do @(posedge i_clk); while (!(i_valid && o_ready));
    endtask

    // Registers are written only with the block idle: no request offered
    // and every expected result already taken. Each request yields exactly
    // one result, so an empty scoreboard means the block is idle.
    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data val);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (due_reports.size() != 0);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_INIT_WINDOW: reg_init_window = val;
            CFG_INIT_THRESH: ;   // taken by the block, used only at reset
            CFG_RTT:         reg_rtt = val[RTT_BITS-1:0];
            CFG_TOTAL:       reg_total = val;
            default:         ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_row reg_row(t_cfg_idx idx, t_cfg_data val);
        t_row r;
        r          = '0;
        r.is_write = 1'b1;
        r.idx      = idx;
        r.data     = val;
        return r;
    endfunction

    function automatic t_row req_row(t_op op, t_seq ack, t_time now);
        t_row r;
        r     = '0;
        r.op  = op;
        r.ack = ack;
        r.now = now;
        return r;
    endfunction

    function automatic t_row req_known(t_op op, t_seq ack, t_time now, t_win w, t_win th,
                                       logic av, logic rs, t_seq rsq, logic dn);
        t_row r;
        r       = req_row(op, ack, now);
        r.typed = 1'b1;
        r.want  = '{window_size: w, threshold: th, avoid_mode: av, resend: rs,
                    resend_sequence: rsq, transfer_done: dn};
        return r;
    endfunction

    initial begin : stimulus
        t_row        plan [$];
        t_time       sec;
        logic [31:0] next_ack;
        int          sent;
        int          run;
        t_cfg_data   val;

        // Directed part, starting from the reset registers: window 1,
        // threshold 64, two seconds per round trip, zero packets in total.
        // Zero acks against a zero total: done, and the triple skips the loss.
        plan.push_back(req_known(OP_ACK, 16'd0, 32'd0, 16'd1, 16'd64, 1'b0, 1'b0, 16'd0, 1'b1));
        plan.push_back(req_known(OP_ACK, 16'd0, 32'd0, 16'd1, 16'd64, 1'b0, 1'b0, 16'd0, 1'b1));
        plan.push_back(req_known(OP_ACK, 16'd0, 32'd0, 16'd1, 16'd64, 1'b0, 1'b0, 16'd0, 1'b1));
        // Slow start growth, then a triple duplicate in slow start and a
        // repeated duplicate that throws avoidance back to slow start.
        plan.push_back(req_known(OP_ACK, 16'd3, 32'd1, 16'd2, 16'd64, 1'b0, 1'b0, 16'd0, 1'b0));
        plan.push_back(req_row(OP_ACK, 16'd3, 32'hFFFF_FFFF));
        plan.push_back(req_known(OP_ACK, 16'd3, 32'd1, 16'd2, 16'd2, 1'b1, 1'b1, 16'd4, 1'b0));
        plan.push_back(req_known(OP_ACK, 16'd3, 32'd2, 16'd1, 16'd2, 1'b0, 1'b1, 16'd4, 1'b0));
        // A loss event in slow start, with both fields at their maximum.
        plan.push_back(req_known(OP_LOSS, 16'hFFFF, 32'hFFFF_FFFF,
                                 16'd1, 16'd2, 1'b1, 1'b0, 16'd0, 1'b0));
        // Avoidance growth once per round trip; the third one runs backwards.
        plan.push_back(req_row(OP_ACK, 16'd5, 32'd1));
        plan.push_back(req_row(OP_ACK, 16'd6, 32'd2));
        plan.push_back(req_row(OP_ACK, 16'd7, 32'd1));
        plan.push_back(req_row(OP_ACK, 16'd8, 32'd3));
        plan.push_back(req_row(OP_LOSS, 16'd0, 32'd0));
        // An initial window of zero acts as one; a zero round trip grows on
        // every new ack; the transfer completes at ten packets.
        plan.push_back(reg_row(CFG_INIT_WINDOW, 16'd0));
        plan.push_back(reg_row(CFG_RTT, 16'd0));
        plan.push_back(reg_row(CFG_TOTAL, 16'd10));
        plan.push_back(reg_row(CFG_INIT_THRESH, 16'd0));
        plan.push_back(req_row(OP_ACK, 16'd9, 32'd4));
        plan.push_back(req_known(OP_ACK, 16'd10, 32'd4, 16'd3, 16'd2, 1'b1, 1'b0, 16'd0, 1'b1));
        plan.push_back(req_known(OP_LOSS, 16'd0, 32'd0, 16'd1, 16'd2, 1'b0, 1'b0, 16'd0, 1'b1));
        plan.push_back(req_known(OP_ACK, 16'd10, 32'd5, 16'd1, 16'd2, 1'b0, 1'b0, 16'd0, 1'b1));
        plan.push_back(req_known(OP_ACK, 16'd10, 32'd5, 16'd1, 16'd2, 1'b0, 1'b0, 16'd0, 1'b1));
        // All registers at their maximum: the same triple now is a loss, and
        // the window saturates at the top.
        plan.push_back(reg_row(CFG_INIT_WINDOW, 16'hFFFF));
        plan.push_back(reg_row(CFG_RTT, 16'hFFFF));
        plan.push_back(reg_row(CFG_TOTAL, 16'hFFFF));
        plan.push_back(reg_row(CFG_INIT_THRESH, 16'hFFFF));
        plan.push_back(req_known(OP_ACK, 16'd10, 32'd5, 16'd1, 16'd2, 1'b1, 1'b1, 16'd11, 1'b0));
        plan.push_back(req_known(OP_ACK, 16'd10, 32'd5,
                                 16'hFFFF, 16'd2, 1'b0, 1'b1, 16'd11, 1'b0));
        plan.push_back(req_known(OP_ACK, 16'd11, 32'd6,
                                 16'hFFFF, 16'd2, 1'b1, 1'b0, 16'd0, 1'b0));
        plan.push_back(req_row(OP_ACK, 16'd12, 32'd261));
        plan.push_back(req_known(OP_LOSS, 16'd0, 32'd0,
                                 16'hFFFF, 16'h7FFF, 1'b0, 1'b0, 16'd0, 1'b0));
        plan.push_back(req_known(OP_ACK, 16'd13, 32'd262,
                                 16'hFFFF, 16'h7FFF, 1'b1, 1'b0, 16'd0, 1'b0));

        do @(posedge i_clk); while (!i_rst_n);

        foreach (plan[k]) begin
            if (plan[k].is_write) begin
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                send_request(plan[k].op, plan[k].ack, plan[k].now,
                             plan[k].typed, plan[k].want);
            end
        end

        // Random part. The acked count never falls and reset is never
        // repeated, so new acks climb in steps that spread over the whole
        // ack range across the run. Duplicate runs build triples, stale acks
        // and loss events break them, and times mostly move forward.
        sec = 32'd300;
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       val = 16'd0;
                1:       val = 16'hFFFF;
                2:       val = 16'd1;
                default: val = t_cfg_data'($urandom_range(1, 64));
            endcase
            write_reg(CFG_INIT_WINDOW, val);
            write_reg(CFG_INIT_THRESH, t_cfg_data'($urandom));
            case ($urandom_range(0, 3))
                0:       val = 16'd0;
                1:       val = 16'd255;
                default: val = t_cfg_data'($urandom_range(1, 6));
            endcase
            // The upper byte is outside the round trip register.
            val[CFG_DATA_BITS-1:RTT_BITS] = (CFG_DATA_BITS - RTT_BITS)'($urandom);
            write_reg(CFG_RTT, val);
            case ($urandom_range(0, 4))
                0:       next_ack = 32'd0;
                1:       next_ack = 32'hFFFF;
                default: next_ack = 32'(sent_top) + $urandom_range(1, 1500);
            endcase
            write_reg(CFG_TOTAL, (next_ack > 32'hFFFF) ? 16'hFFFF : t_cfg_data'(next_ack));

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7: begin
                        // New acknowledgement: a small step, a jump straight
                        // to the end of the transfer, or a large step.
                        case ($urandom_range(0, 2))
                            0: next_ack = 32'(sent_top) + $urandom_range(1, 3);
                            1: next_ack = (reg_total > sent_top) ? 32'(reg_total)
                                        : 32'(sent_top) + $urandom_range(1, 900);
                            default: next_ack = 32'(sent_top) + $urandom_range(1, 900);
                        endcase
                        if (next_ack > 32'hFFFF) begin
                            next_ack = 32'hFFFF;
                        end
                        sec = sec + $urandom_range(0, 3);
                        send_request(OP_ACK, t_seq'(next_ack),
                                     ($urandom_range(0, 15) == 0) ?
                                         sec - $urandom_range(1, 5) : sec,
                                     1'b0, '0);
                        sent++;
                    end
                    8, 9, 10, 11, 12: begin
                        // Run of repeats of the latest ack number.
                        run = $urandom_range(1, 4);
                        repeat (run) begin
                            send_request(OP_ACK, sent_last,
                                         ($urandom_range(0, 3) == 0) ? t_time'($urandom) : sec,
                                         1'b0, '0);
                        end
                        sent += run;
                    end
                    13, 14, 15: begin
                        // Stale acknowledgement at or below the acked count.
                        send_request(OP_ACK, t_seq'($urandom_range(0, sent_top)),
                                     ($urandom_range(0, 1) == 0) ? t_time'($urandom) : sec,
                                     1'b0, '0);
                        sent++;
                    end
                    default: begin
                        // Loss event; the ack and time fields are noise.
                        send_request(OP_LOSS, t_seq'($urandom), t_time'($urandom), 1'b0, '0);
                        sent++;
                    end
                endcase
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (due_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[congestion_window_control] OK");
        end else begin
            $display("[congestion_window_control] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== congestion_window_control.f =====
sv/cwc_pkg.sv
sv/cwc_update.sv
sv/congestion_window_control.sv
sv/cwc_checker.sv
bench/testbench.sv
